// ----- design/utf16_escape_line_decoder_defines.svh -----
// Assertion macros used by the checker file.
`ifndef UTF16_ESCAPE_LINE_DECODER_DEFINES_SVH
`define UTF16_ESCAPE_LINE_DECODER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define U16ESC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check an implication whose consequent is due in the next cycle.
`define U16ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/u16esc_pkg.sv -----
`default_nettype none

package u16esc_pkg;

    // Line counter width
    localparam int unsigned LINE_COUNT_BITS_DEF = 16;

    // Code units of interest
    localparam logic [15:0] BOM_UNIT   = 16'hFEFF;
    localparam logic [15:0] CR_UNIT    = 16'h000D;
    localparam logic [15:0] LF_UNIT    = 16'h000A;
    localparam logic [15:0] TAB_UNIT   = 16'h0009;
    localparam logic [15:0] BSL_UNIT   = 16'h005C;
    localparam logic [15:0] QUOTE_UNIT = 16'h0027;
    localparam logic [15:0] DQUOTE_UNIT = 16'h0022;
    localparam logic [15:0] T_UNIT     = 16'h0074;
    localparam logic [15:0] N_UNIT     = 16'h006E;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DATA    = 2'd0,
        ST_NO_BOM  = 2'd1,
        ST_BAD_ESC = 2'd2
    } t_status;

    // Decoder flags carried from one beat to the next
    typedef struct packed {
        logic escape_pending;
        logic after_cr;
        logic stopped;
    } t_flags;

    // Decode outcome for one beat
    typedef struct packed {
        logic        emit;
        logic        clear_count;
        logic        inc_count;
        t_status     status;
        logic [15:0] out_unit;
        t_flags      next_flags;
    } t_decode;

    // Place bytes in output order
    function automatic logic [15:0] order_bytes(input logic [15:0] unit, input logic swap);
        order_bytes = swap ? {unit[7:0], unit[15:8]} : unit;
    endfunction

endpackage

`default_nettype wire

// ----- design/utf16_escape_line_decoder.sv -----
// The result of an accepted input beat is registered and shows on o_valid in the next cycle.
// Throughput: one input beat per cycle; the result register sits between the
// two sides, so input is taken whenever that register is empty or being drained.
// A beat that yields no result (mark, opening backslash, LF of CR-LF, beat after a stop) leaves it empty.
// Reset (synchronous, i_rst_n low) clears swap_bytes, all decoder flags,
// the line counter and the result valid.
`default_nettype none

module utf16_escape_line_decoder #(
    parameter int unsigned LINE_COUNT_BITS = u16esc_pkg::LINE_COUNT_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_first_unit,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_out_unit,
    output logic [1:0]       o_status,
    output logic [15:0]      o_lines_seen
);
    import u16esc_pkg::*;

    logic                       r_swap;
    t_flags                     r_flags;
    logic [LINE_COUNT_BITS-1:0] r_count;
    logic [LINE_COUNT_BITS-1:0] n_count;
    logic                       r_out_valid;
    logic [15:0]                r_out_unit;
    t_status                    r_status;
    logic [15:0]                r_lines;
    logic [15:0]                w_lines;
    logic                       w_accept;
    t_decode                    w_dec;

    // Take a beat when the result register is free or draining
    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    u16esc_decode u_decode (
        .i_code_unit  (i_code_unit),
        .i_first_unit (i_first_unit),
        .i_swap       (r_swap),
        .i_flags      (r_flags),
        .o_dec        (w_dec)
    );

    // Advance the saturating line counter
    always_comb begin
        n_count = r_count;
        if (w_dec.clear_count) begin
            n_count = '0;
        end else if (w_dec.inc_count && r_count != {LINE_COUNT_BITS{1'b1}}) begin
            n_count = r_count + 1'b1;
        end
    end

    // Clamp the count to the 16-bit report
    generate
        if (LINE_COUNT_BITS > 16) begin : g_wide
            assign w_lines = (|n_count[LINE_COUNT_BITS-1:16]) ? 16'hFFFF : n_count[15:0];
        end else if (LINE_COUNT_BITS == 16) begin : g_equal
            assign w_lines = n_count;
        end else begin : g_narrow
            assign w_lines = {{(16 - LINE_COUNT_BITS){1'b0}}, n_count};
        end
    endgenerate

    // Hold configuration and decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap  <= 1'b0;
            r_flags <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_swap <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_flags <= w_dec.next_flags;
                r_count <= n_count;
            end
        end
    end

    // Result valid: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= w_dec.emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept && w_dec.emit) begin
            r_out_unit <= w_dec.out_unit;
            r_status   <= w_dec.status;
            r_lines    <= w_lines;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_unit   = r_out_unit;
    assign o_status     = r_status;
    assign o_lines_seen = r_lines;

endmodule

`default_nettype wire

// ----- design/u16esc_decode.sv -----
`default_nettype none

module u16esc_decode (
    input  wire logic [15:0]        i_code_unit,
    input  wire logic               i_first_unit,
    input  wire logic               i_swap,
    input  wire u16esc_pkg::t_flags i_flags,
    output u16esc_pkg::t_decode     o_dec
);
    import u16esc_pkg::*;

    // Decode one unit against the carried flags
    always_comb begin
        o_dec             = '0;
        o_dec.status      = ST_DATA;
        o_dec.next_flags  = i_flags;
        if (i_first_unit) begin
            // start of file: clear everything, check the mark
            o_dec.next_flags  = '0;
            o_dec.clear_count = 1'b1;
            if (i_code_unit != BOM_UNIT) begin
                o_dec.next_flags.stopped = 1'b1;
                o_dec.emit               = 1'b1;
                o_dec.status             = ST_NO_BOM;
            end
        end else if (!i_flags.stopped) begin
            o_dec.next_flags.after_cr = 1'b0;
            if (i_flags.escape_pending) begin
                // complete the escape
                o_dec.next_flags.escape_pending = 1'b0;
                o_dec.emit                      = 1'b1;
                priority if (i_code_unit == T_UNIT) begin
                    o_dec.out_unit = order_bytes(TAB_UNIT, i_swap);
                end else if (i_code_unit == N_UNIT) begin
                    o_dec.out_unit = order_bytes(LF_UNIT, i_swap);
                end else if (i_code_unit == BSL_UNIT || i_code_unit == QUOTE_UNIT
                             || i_code_unit == DQUOTE_UNIT) begin
                    o_dec.out_unit = order_bytes(i_code_unit, i_swap);
                end else begin
                    o_dec.next_flags.stopped = 1'b1;
                    o_dec.status             = ST_BAD_ESC;
                end
            end else if (i_code_unit == BSL_UNIT) begin
                // open an escape, hold the result
                o_dec.next_flags.escape_pending = 1'b1;
            end else if (i_code_unit == LF_UNIT && i_flags.after_cr) begin
                // drop the LF of a CR-LF pair
                o_dec.emit = 1'b0;
            end else if (i_code_unit == CR_UNIT || i_code_unit == LF_UNIT) begin
                // line break becomes one NUL unit
                o_dec.next_flags.after_cr = (i_code_unit == CR_UNIT);
                o_dec.inc_count           = 1'b1;
                o_dec.emit                = 1'b1;
            end else begin
                o_dec.emit     = 1'b1;
                o_dec.out_unit = order_bytes(i_code_unit, i_swap);
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/u16esc_checker.sv -----
`default_nettype none
`include "utf16_escape_line_decoder_defines.svh"

module u16esc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [15:0] o_out_unit,
    input wire logic [1:0]  o_status,
    input wire logic [15:0] o_lines_seen
);
    import u16esc_pkg::*;

    logic        w_err_beat;
    logic        w_no_bom_beat;
    logic        w_unit_zero;
    logic        w_lines_zero;
    logic        w_known_status;
    logic        w_stall;
    logic [33:0] w_payload;

    // Decode the result beat into short terms
    assign w_err_beat     = o_valid && (o_status != ST_DATA);
    assign w_no_bom_beat  = o_valid && (o_status == ST_NO_BOM);
    assign w_unit_zero    = (o_out_unit == 16'h0000);
    assign w_lines_zero   = (o_lines_seen == 16'h0000);
    assign w_known_status = (o_status == ST_DATA) || (o_status == ST_NO_BOM)
                            || (o_status == ST_BAD_ESC);
    assign w_stall        = o_valid && !i_ready;
    assign w_payload      = {o_out_unit, o_status, o_lines_seen};

    // Error beats carry no unit
    `U16ESC_ASSERT(a_err_unit, i_clk, i_rst_n, w_err_beat |-> w_unit_zero, "unit on error beat")

    // A missing mark resets the line count
    `U16ESC_ASSERT(a_no_bom_lines, i_clk, i_rst_n, w_no_bom_beat |-> w_lines_zero, "lines on no mark")

    // Only defined status codes appear
    `U16ESC_ASSERT(a_status_code, i_clk, i_rst_n, o_valid |-> w_known_status, "undefined status code")

    // A stalled result holds
    `U16ESC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, o_valid && $stable(w_payload), "stall changed")

endmodule

bind utf16_escape_line_decoder u16esc_checker u_checker (.*);

`default_nettype wire
